FILE: hw/rtl/cor_pkg.sv
// Shared types, constants and helpers for the circle overlap resolver.
package cor_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam logic [30:0] RADIUS_SUM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic [30:0]        ax;
        logic [30:0]        ay;
        logic               sx;
        logic               sy;
        logic               far;
        logic [30:0]        rmin;
    } t_sq_side;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic               sx;
        logic               sy;
        logic               hit;
    } t_dv_side;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/circle_overlap_resolver.sv
// Top level of the circle overlap resolver pipeline.
// Takes one circle pair per cycle, unless stalled, and returns the corrected
// centres through 3 stages of axis and squaring, 32 square-root stages (one root bit
// each), 3 stages of overlap and numerator, 31 divider stages (one quotient bit
// each) and an output register. The whole pipeline holds while the output
// request is stalled; o_stall follows i_stall whenever the output holds a
// result. Coincident or non-overlapping pairs pass through with o_overlapped low.
module circle_overlap_resolver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic [30:0]        i_first_radius,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic [30:0]        i_second_radius,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_first_x,
    output logic signed [31:0] o_new_first_y,
    output logic signed [31:0] o_new_second_x,
    output logic signed [31:0] o_new_second_y,
    output logic               o_overlapped
);

    logic en;

    // stage 1: axis, magnitudes, radius sum
    logic              r1_valid;
    cor_pkg::t_sq_side r1_side;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [32:0]        w_ax;
    logic [32:0]        w_ay;
    logic [31:0]        w_rsum;
    cor_pkg::t_sq_side  n1_side;

    // stage 2: squares
    logic              r2_valid;
    cor_pkg::t_sq_side r2_side;
    logic [61:0]       r2_sqx;
    logic [61:0]       r2_sqy;

    // stage 3: sum of squares
    logic              r3_valid;
    cor_pkg::t_sq_side r3_side;
    logic [62:0]       r3_s;

    logic              sq_valid;
    logic [31:0]       sq_root;
    cor_pkg::t_sq_side sq_side;

    // stage 4: overlap test
    logic              r4_valid;
    cor_pkg::t_dv_side r4_side;
    logic [30:0]       r4_delta;
    logic [30:0]       r4_dist;
    logic [30:0]       r4_ax;
    logic [30:0]       r4_ay;
    logic              n4_hit;

    // stage 5: numerators
    logic              r5_valid;
    cor_pkg::t_dv_side r5_side;
    logic [61:0]       r5_nx;
    logic [61:0]       r5_ny;
    logic [30:0]       r5_dist;

    // stage 6: rounding bias
    logic              r6_valid;
    cor_pkg::t_dv_side r6_side;
    logic [62:0]       r6_nx;
    logic [62:0]       r6_ny;
    logic [31:0]       r6_den;

    logic              dv_valid;
    logic [30:0]       dv_qx;
    logic [30:0]       dv_qy;
    cor_pkg::t_dv_side dv_side;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_x1;
    logic signed [31:0] r_y1;
    logic signed [31:0] r_x2;
    logic signed [31:0] r_y2;
    logic               r_hit;

    logic signed [32:0] w_px;
    logic signed [32:0] w_py;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        w_dx   = {i_first_x[31], i_first_x} - {i_second_x[31], i_second_x};
        w_dy   = {i_first_y[31], i_first_y} - {i_second_y[31], i_second_y};
        w_ax   = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        w_ay   = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
        w_rsum = {1'b0, i_first_radius} + {1'b0, i_second_radius};
        n1_side.x1   = i_first_x;
        n1_side.y1   = i_first_y;
        n1_side.x2   = i_second_x;
        n1_side.y2   = i_second_y;
        n1_side.ax   = w_ax[30:0];
        n1_side.ay   = w_ay[30:0];
        n1_side.sx   = w_dx[32];
        n1_side.sy   = w_dy[32];
        n1_side.far  = w_ax[32] | w_ax[31] | w_ay[32] | w_ay[31];
        n1_side.rmin = w_rsum[31] ? cor_pkg::RADIUS_SUM_MAX : w_rsum[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        if (en) begin
            r1_side <= n1_side;
            r2_side <= r1_side;
            r2_sqx  <= r1_side.ax * r1_side.ax;
            r2_sqy  <= r1_side.ay * r1_side.ay;
            r3_side <= r2_side;
            r3_s    <= {1'b0, r2_sqx} + {1'b0, r2_sqy};
        end
    end

    cor_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_rad   (r3_s),
        .i_side  (r3_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign n4_hit = !sq_side.far && (sq_root != 32'd0) && (sq_root < {1'b0, sq_side.rmin});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= sq_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
        if (en) begin
            r4_side.x1  <= sq_side.x1;
            r4_side.y1  <= sq_side.y1;
            r4_side.x2  <= sq_side.x2;
            r4_side.y2  <= sq_side.y2;
            r4_side.sx  <= sq_side.sx;
            r4_side.sy  <= sq_side.sy;
            r4_side.hit <= n4_hit;
            r4_delta    <= sq_side.rmin - sq_root[30:0];
            r4_dist     <= sq_root[30:0];
            r4_ax       <= sq_side.ax;
            r4_ay       <= sq_side.ay;
            r5_side     <= r4_side;
            r5_nx       <= r4_delta * r4_ax;
            r5_ny       <= r4_delta * r4_ay;
            r5_dist     <= r4_dist;
            r6_side     <= r5_side;
            r6_nx       <= {1'b0, r5_nx} + {32'd0, r5_dist};
            r6_ny       <= {1'b0, r5_ny} + {32'd0, r5_dist};
            r6_den      <= {r5_dist, 1'b0};
        end
    end

    cor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_valid),
        .i_num_x (r6_nx),
        .i_num_y (r6_ny),
        .i_den   (r6_den),
        .i_side  (r6_side),
        .o_valid (dv_valid),
        .o_q_x   (dv_qx),
        .o_q_y   (dv_qy),
        .o_side  (dv_side)
    );

    assign w_px = dv_side.sx ? -$signed({2'b00, dv_qx}) : $signed({2'b00, dv_qx});
    assign w_py = dv_side.sy ? -$signed({2'b00, dv_qy}) : $signed({2'b00, dv_qy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
        if (en) begin
            r_hit <= dv_side.hit;
            if (dv_side.hit) begin
                r_x1 <= cor_pkg::sat32(34'(dv_side.x1) + 34'(w_px));
                r_y1 <= cor_pkg::sat32(34'(dv_side.y1) + 34'(w_py));
                r_x2 <= cor_pkg::sat32(34'(dv_side.x2) - 34'(w_px));
                r_y2 <= cor_pkg::sat32(34'(dv_side.y2) - 34'(w_py));
            end else begin
                r_x1 <= dv_side.x1;
                r_y1 <= dv_side.y1;
                r_x2 <= dv_side.x2;
                r_y2 <= dv_side.y2;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_new_first_x  = r_x1;
    assign o_new_first_y  = r_y1;
    assign o_new_second_x = r_x2;
    assign o_new_second_y = r_y2;
    assign o_overlapped   = r_hit;

endmodule

FILE: hw/rtl/cor_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cor_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [62:0]        i_rad,
    input  cor_pkg::t_sq_side  i_side,
    output logic               o_valid,
    output logic [31:0]        o_root,
    output cor_pkg::t_sq_side  o_side
);

    localparam int N = cor_pkg::SQRT_STAGES;

    logic               r_valid [0:N-1];
    logic [34:0]        r_rem   [0:N-1];
    logic [31:0]        r_root  [0:N-1];
    logic [63:0]        r_s     [0:N-1];
    cor_pkg::t_sq_side  r_side  [0:N-1];

    logic               w_valid [0:N-1];
    logic [34:0]        w_rem   [0:N-1];
    logic [31:0]        w_root  [0:N-1];
    logic [63:0]        w_s     [0:N-1];
    cor_pkg::t_sq_side  w_side  [0:N-1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_s[0]     = {1'b0, i_rad};
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [34:0] cur;
        logic [34:0] trial;
        logic [34:0] n_rem;
        logic [31:0] n_root;

        if (k > 0) begin : g_link
            assign w_valid[k] = r_valid[k-1];
            assign w_rem[k]   = r_rem[k-1];
            assign w_root[k]  = r_root[k-1];
            assign w_s[k]     = r_s[k-1];
            assign w_side[k]  = r_side[k-1];
        end

        always_comb begin
            cur   = {w_rem[k][32:0], w_s[k][63:62]};
            trial = {1'b0, w_root[k], 2'b01};
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {w_root[k][30:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {w_root[k][30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid[k];
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_s[k]    <= {w_s[k][61:0], 2'b00};
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

FILE: hw/rtl/cor_div.sv
// Pipelined restoring divider, two lanes sharing one divisor.
module cor_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [62:0]        i_num_x,
    input  logic [62:0]        i_num_y,
    input  logic [31:0]        i_den,
    input  cor_pkg::t_dv_side  i_side,
    output logic               o_valid,
    output logic [30:0]        o_q_x,
    output logic [30:0]        o_q_y,
    output cor_pkg::t_dv_side  o_side
);

    localparam int N = cor_pkg::DIV_STAGES;

    logic               r_valid [0:N-1];
    logic [31:0]        r_rx    [0:N-1];
    logic [31:0]        r_ry    [0:N-1];
    logic [30:0]        r_lx    [0:N-1];
    logic [30:0]        r_ly    [0:N-1];
    logic [30:0]        r_qx    [0:N-1];
    logic [30:0]        r_qy    [0:N-1];
    logic [31:0]        r_den   [0:N-1];
    cor_pkg::t_dv_side  r_side  [0:N-1];

    logic               w_valid [0:N-1];
    logic [31:0]        w_rx    [0:N-1];
    logic [31:0]        w_ry    [0:N-1];
    logic [30:0]        w_lx    [0:N-1];
    logic [30:0]        w_ly    [0:N-1];
    logic [30:0]        w_qx    [0:N-1];
    logic [30:0]        w_qy    [0:N-1];
    logic [31:0]        w_den   [0:N-1];
    cor_pkg::t_dv_side  w_side  [0:N-1];

    // quotient fits 31 bits, so the upper numerator part starts as remainder
    assign w_valid[0] = i_valid;
    assign w_rx[0]    = i_num_x[62:31];
    assign w_ry[0]    = i_num_y[62:31];
    assign w_lx[0]    = i_num_x[30:0];
    assign w_ly[0]    = i_num_y[30:0];
    assign w_qx[0]    = '0;
    assign w_qy[0]    = '0;
    assign w_den[0]   = i_den;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [32:0] cx;
        logic [32:0] cy;
        logic [31:0] n_rx;
        logic [31:0] n_ry;
        logic        bx;
        logic        by;

        if (k > 0) begin : g_link
            assign w_valid[k] = r_valid[k-1];
            assign w_rx[k]    = r_rx[k-1];
            assign w_ry[k]    = r_ry[k-1];
            assign w_lx[k]    = r_lx[k-1];
            assign w_ly[k]    = r_ly[k-1];
            assign w_qx[k]    = r_qx[k-1];
            assign w_qy[k]    = r_qy[k-1];
            assign w_den[k]   = r_den[k-1];
            assign w_side[k]  = r_side[k-1];
        end

        always_comb begin
            cx = {w_rx[k], w_lx[k][30]};
            cy = {w_ry[k], w_ly[k][30]};
            bx = (cx >= {1'b0, w_den[k]});
            by = (cy >= {1'b0, w_den[k]});
            n_rx = bx ? 32'(cx - {1'b0, w_den[k]}) : cx[31:0];
            n_ry = by ? 32'(cy - {1'b0, w_den[k]}) : cy[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid[k];
            end
            if (i_en) begin
                r_rx[k]   <= n_rx;
                r_ry[k]   <= n_ry;
                r_lx[k]   <= {w_lx[k][29:0], 1'b0};
                r_ly[k]   <= {w_ly[k][29:0], 1'b0};
                r_qx[k]   <= {w_qx[k][29:0], bx};
                r_qy[k]   <= {w_qy[k][29:0], by};
                r_den[k]  <= w_den[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_q_x   = r_qx[N-1];
    assign o_q_y   = r_qy[N-1];
    assign o_side  = r_side[N-1];

endmodule

FILE: verif/tb_top.sv
// Testbench for the circle overlap resolver: random and directed circle pairs, scoreboard check.
`timescale 1ns / 100ps

class pair_scoreboard;
    typedef struct {
        logic signed [31:0] fx, fy, sx, sy;
        logic               hit;
    } t_pos;

    t_pos pending[$];
    int   errors;

    function automatic logic [63:0] root64(logic [63:0] s);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint push(longint d, longint unsigned ovl, longint unsigned dlen);
        longint unsigned ad, mag;
        ad  = (d < 0) ? -d : d;
        mag = (ovl * ad + dlen) / (dlen * 2);
        return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [31:0] clip(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function void note_pair(logic signed [31:0] x1, y1, logic [30:0] r1,
                            logic signed [31:0] x2, y2, logic [30:0] r2);
        longint dx, dy, a1, b1, a2, b2, px, py;
        longint unsigned rsum, ax, ay, dlen;
        t_pos e;
        a1 = x1; b1 = y1; a2 = x2; b2 = y2;
        dx = a1 - a2; dy = b1 - b2;
        rsum = longint'(r1) + longint'(r2);
        if (rsum > 64'h7FFF_FFFF) rsum = 64'h7FFF_FFFF;
        e.hit = 0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax < 64'h8000_0000 && ay < 64'h8000_0000) begin
            dlen = root64(ax * ax + ay * ay);
            if (dlen != 0 && dlen < rsum) begin
                px = push(dx, rsum - dlen, dlen);
                py = push(dy, rsum - dlen, dlen);
                a1 += px; b1 += py; a2 -= px; b2 -= py;
                e.hit = 1;
            end
        end
        e.fx = clip(a1); e.fy = clip(b1); e.sx = clip(a2); e.sy = clip(b2);
        pending.push_back(e);
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic signed [31:0] fx, fy, sx, sy, logic hit);
        t_pos e;
        if (pending.size() == 0) begin
            report("result with nothing pending");
            return;
        end
        e = pending.pop_front();
        if (fx !== e.fx) report($sformatf("first_x %h exp %h", fx, e.fx));
        if (fy !== e.fy) report($sformatf("first_y %h exp %h", fy, e.fy));
        if (sx !== e.sx) report($sformatf("second_x %h exp %h", sx, e.sx));
        if (sy !== e.sy) report($sformatf("second_y %h exp %h", sy, e.sy));
        if (hit !== e.hit) report($sformatf("overlapped %b exp %b", hit, e.hit));
    endtask
endclass

module tb_top;
    logic               i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_overlapped;
    logic signed [31:0] i_first_x, i_first_y, i_second_x, i_second_y;
    logic [30:0]        i_first_radius, i_second_radius;
    logic signed [31:0] o_new_first_x, o_new_first_y, o_new_second_x, o_new_second_y;

    pair_scoreboard board;
    int  cycles;

    circle_overlap_resolver dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_first_x = 0; i_first_y = 0; i_second_x = 0; i_second_y = 0;
        i_first_radius = 0; i_second_radius = 0;
        board = new();
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_new_first_x, o_new_first_y, o_new_second_x,
                               o_new_second_y, o_overlapped);
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall stretches, with calm phases
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 1) == 0) w = 0;
            if (w > 0) begin
                i_stall <= 1;
                repeat (w) @(negedge i_clk);
            end
            i_stall <= 0;
        end
    end

    task send_pair(logic signed [31:0] x1, y1, logic [30:0] r1,
                   logic signed [31:0] x2, y2, logic [30:0] r2, int gap);
        repeat (gap) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_first_x <= x1; i_first_y <= y1; i_first_radius <= r1;
        i_second_x <= x2; i_second_y <= y2; i_second_radius <= r2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_pair(x1, y1, r1, x2, y2, r2);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    initial begin
        int g, k;
        logic signed [31:0] cx, cy;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // directed corners
        send_pair(0, 0, 31'h1_0000, 0, 0, 31'h1_0000, 0);               // coincident
        send_pair(32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF, 32'sh8000_0000, 0, 31'h7FFF_FFFF, 0);
        send_pair(32'sh8000_0000, 32'sh8000_0000, 31'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  31'd0, 1);
        send_pair(32'sh7FFF_0000, 32'sh7FFF_0000, 31'h7FFF_FFFF, 32'sh7FFE_0000,
                  32'sh7FFE_0000, 31'h7FFF_FFFF, 0);                    // saturate high
        send_pair(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8001_0000,
                  32'sh8001_0000, 31'h7FFF_FFFF, 0);                    // saturate low
        send_pair(0, 0, 31'h1_0000, 32'sh2_0000, 0, 31'h1_0000, 0);       // touching
        send_pair(0, 0, 31'h1_0000, 32'sh1_0000, 0, 31'h1_0000, 2);       // overlap on x
        send_pair(0, 32'sh1_0000, 31'h1_0000, 0, 0, 31'h1_0000, 0);       // overlap on y
        send_pair(1, 1, 31'd0, 0, 0, 31'd0, 0);
        send_pair(1, 0, 31'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 0);
        send_pair(-1, -1, 31'h0_8000, 0, 0, 31'h0_8000, 0);
        send_pair(32'sh4000_0000, 0, 31'd0, 32'shC000_0000, 0, 31'h7FFF_FFFF, 0);
        for (k = 0; k < 1700; k++) begin
            g = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            if (k == 850) begin
                i_valid <= 0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
            case ($urandom_range(0, 3))
                0: send_pair(rnd32(), rnd32(), 31'(rnd32()), rnd32(), rnd32(),
                             31'(rnd32()), g);
                1: begin
                    cx = rnd32();
                    cy = rnd32();
                    send_pair(cx, cy, 31'($urandom_range(0, 32'h40_0000)),
                              cx + $signed(rnd32() >>> $urandom_range(8, 31)),
                              cy + $signed(rnd32() >>> $urandom_range(8, 31)),
                              31'($urandom_range(0, 32'h40_0000)), g);
                end
                2: begin
                    cx = rnd32() >>> $urandom_range(0, 20);
                    cy = rnd32() >>> $urandom_range(0, 20);
                    send_pair(cx, cy, 31'(rnd32() >> $urandom_range(1, 20)),
                              cx + ($signed(rnd32()) >>> $urandom_range(4, 31)),
                              cy + ($signed(rnd32()) >>> $urandom_range(4, 31)),
                              31'(rnd32() >> $urandom_range(1, 20)), g);
                end
                default: begin
                    cx = $urandom_range(0, 1) ? 32'sh7FFF_0000 + $urandom_range(0, 16'hFFFF)
                                              : 32'sh8000_0000 + $urandom_range(0, 16'hFFFF);
                    send_pair(cx, rnd32(), 31'(rnd32()),
                              cx + $signed($urandom_range(0, 16'hFFFF)),
                              rnd32(), 31'(rnd32()), g);
                end
            endcase
        end
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
